// ----- hw/rtl/life_grid_engine_assert.svh -----
// Assertion macros shared by the life grid engine RTL.
`ifndef LIFE_GRID_ENGINE_ASSERT_SVH
`define LIFE_GRID_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LGE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LGE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/lge_pkg.sv -----
// Types and constants of the life grid engine.
package lge_pkg;

	localparam int SIZE_W  = 7;
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 4;

	localparam logic [SIZE_W-1:0]  SIZE_RESET    = 7'd64;
	localparam logic [COUNT_W-1:0] BIRTH_COUNT   = 4'd3;
	localparam logic [COUNT_W-1:0] SURVIVE_COUNT = 4'd2;

	typedef enum logic [1:0] {
		ACT_TOGGLE  = 2'd0,
		ACT_READ    = 2'd1,
		ACT_CLEAR   = 2'd2,
		ACT_ADVANCE = 2'd3
	} action_t;

	typedef enum logic {
		REG_USED_COLUMNS = 1'b0,
		REG_USED_ROWS    = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		action_t             action;
		logic [INDEX_W-1:0]  column_index;
		logic [INDEX_W-1:0]  row_index;
	} cmd_t;

	typedef struct packed {
		logic cell_value;
		logic status;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_CELL,
		ST_ADV_RD0,
		ST_ADV_RD1,
		ST_ADV_RD2,
		ST_ADV_CELL,
		ST_ADV_WR,
		ST_DONE
	} state_t;

endpackage

// ----- hw/rtl/lge_cell_rule.sv -----
// Neighbor count and B3/S23 rule for one cell, taken from three column words.
module lge_cell_rule #(
	parameter int ROWS = 64,
	localparam int RW = $clog2(ROWS)
) (
	input  logic [ROWS-1:0] left,
	input  logic [ROWS-1:0] center,
	input  logic [ROWS-1:0] right,
	input  logic [RW-1:0]   row_up,
	input  logic [RW-1:0]   row,
	input  logic [RW-1:0]   row_down,
	output logic            alive_next
);

	logic [lge_pkg::COUNT_W-1:0] count;
	logic                        alive;

	always_comb begin
		count = lge_pkg::COUNT_W'(left[row_up])   + lge_pkg::COUNT_W'(center[row_up])
		      + lge_pkg::COUNT_W'(right[row_up])  + lge_pkg::COUNT_W'(left[row])
		      + lge_pkg::COUNT_W'(right[row])     + lge_pkg::COUNT_W'(left[row_down])
		      + lge_pkg::COUNT_W'(center[row_down]) + lge_pkg::COUNT_W'(right[row_down]);
		alive = center[row];
		if (alive) begin
			alive_next = (count == lge_pkg::SURVIVE_COUNT) || (count == lge_pkg::BIRTH_COUNT);
		end else begin
			alive_next = (count == lge_pkg::BIRTH_COUNT);
		end
	end

endmodule

// ----- hw/rtl/life_grid_engine.sv -----
// Toroidal Game of Life engine: the grid lives in a memory of column words,
// one word of MAX_ROWS bits per column. After reset the block clears that
// memory one column per cycle and only then raises its readiness. An advance
// walks the used grid one cell per cycle through a single rule unit. The block
// takes one word at a time, and a finished result sits in an output register
// so the next word can be taken while it waits.
`include "life_grid_engine_assert.svh"

module life_grid_engine #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  lge_pkg::cfg_reg_t           cfg_index,
	input  logic [lge_pkg::SIZE_W-1:0]  cfg_data,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  lge_pkg::cmd_t               cmd,
	output logic                        res_valid,
	input  logic                        res_stall,
	output lge_pkg::res_t               res
);

	localparam int CAW = $clog2(MAX_COLUMNS);
	localparam int RAW = $clog2(MAX_ROWS);
	localparam logic [CAW-1:0] LAST_COLUMN = CAW'(MAX_COLUMNS - 1);

	lge_pkg::state_t state_q, state_d;

	logic [lge_pkg::SIZE_W-1:0] used_columns_q, used_rows_q;
	logic [lge_pkg::SIZE_W-1:0] cols_used, rows_used, cols_last, rows_last;

	logic [CAW-1:0] c_q, ncl_q, col_addr_q;
	logic [RAW-1:0] r_q, nrl_q, row_q;
	logic           clr_reply_q;
	lge_pkg::action_t action_q;
	logic           oor_q;
	logic           res_value_q, res_status_q;
	logic           res_valid_q;
	lge_pkg::res_t  res_q;
	logic           out_free;
	logic           accept;
	logic           cmd_oor;

	logic [MAX_ROWS-1:0] grid_mem [MAX_COLUMNS];
	logic [MAX_ROWS-1:0] rd_q;
	logic                mem_we;
	logic [CAW-1:0]      mem_waddr, mem_raddr;
	logic [MAX_ROWS-1:0] mem_wdata;

	logic [MAX_ROWS-1:0] left_q, center_q, right_q, first_q, new_q;
	logic [MAX_ROWS-1:0] row_mask;
	logic [RAW-1:0]      row_up, row_down;
	logic                alive_next;
	logic                cell_bit;

	// Used sizes: zero acts as one, anything above the built size saturates.
	always_comb begin
		if (used_columns_q == '0) begin
			cols_used = lge_pkg::SIZE_W'(1);
		end else if (used_columns_q > MAX_COLUMNS) begin
			cols_used = lge_pkg::SIZE_W'(MAX_COLUMNS);
		end else begin
			cols_used = used_columns_q;
		end
		if (used_rows_q == '0) begin
			rows_used = lge_pkg::SIZE_W'(1);
		end else if (used_rows_q > MAX_ROWS) begin
			rows_used = lge_pkg::SIZE_W'(MAX_ROWS);
		end else begin
			rows_used = used_rows_q;
		end
		cols_last = cols_used - lge_pkg::SIZE_W'(1);
		rows_last = rows_used - lge_pkg::SIZE_W'(1);
		cmd_oor = (lge_pkg::SIZE_W'(cmd.column_index) >= cols_used)
		       || (lge_pkg::SIZE_W'(cmd.row_index) >= rows_used);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_columns_q <= lge_pkg::SIZE_RESET;
			used_rows_q    <= lge_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lge_pkg::REG_USED_COLUMNS: used_columns_q <= cfg_data;
				lge_pkg::REG_USED_ROWS:    used_rows_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cmd_stall = (state_q != lge_pkg::ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign out_free  = !res_valid_q || !res_stall;

	// Wrapped row neighbors of the cell under evaluation.
	assign row_up   = (r_q == '0) ? nrl_q : r_q - RAW'(1);
	assign row_down = (r_q == nrl_q) ? '0 : r_q + RAW'(1);

	lge_cell_rule #(
		.ROWS(MAX_ROWS)
	) u_rule (
		.left      (left_q),
		.center    (center_q),
		.right     (right_q),
		.row_up    (row_up),
		.row       (r_q),
		.row_down  (row_down),
		.alive_next(alive_next)
	);

	always_comb begin
		row_mask        = '0;
		row_mask[row_q] = 1'b1;
		cell_bit        = rd_q[row_q];
	end

	// Sequencer: next state and memory port control.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = c_q;
		mem_wdata = new_q;
		mem_raddr = '0;
		unique case (state_q)
			lge_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.action) inside
						lge_pkg::ACT_TOGGLE, lge_pkg::ACT_READ: begin
							mem_raddr = CAW'(cmd.column_index);
							state_d   = lge_pkg::ST_CELL;
						end
						lge_pkg::ACT_CLEAR: begin
							state_d = lge_pkg::ST_CLEAR;
						end
						lge_pkg::ACT_ADVANCE: begin
							mem_raddr = CAW'(cols_last);
							state_d   = lge_pkg::ST_ADV_RD0;
						end
						default: ;
					endcase
				end
			end
			lge_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
				if (c_q == LAST_COLUMN) begin
					state_d = clr_reply_q ? lge_pkg::ST_DONE : lge_pkg::ST_IDLE;
				end
			end
			lge_pkg::ST_CELL: begin
				if (!oor_q && (action_q == lge_pkg::ACT_TOGGLE)) begin
					mem_we    = 1'b1;
					mem_waddr = col_addr_q;
					mem_wdata = rd_q ^ row_mask;
				end
				state_d = lge_pkg::ST_DONE;
			end
			lge_pkg::ST_ADV_RD0: begin
				mem_raddr = '0;
				state_d   = lge_pkg::ST_ADV_RD1;
			end
			lge_pkg::ST_ADV_RD1: begin
				mem_raddr = (ncl_q == '0) ? '0 : CAW'(1);
				state_d   = lge_pkg::ST_ADV_RD2;
			end
			lge_pkg::ST_ADV_RD2: begin
				state_d = lge_pkg::ST_ADV_CELL;
			end
			lge_pkg::ST_ADV_CELL: begin
				if (r_q == nrl_q) begin
					state_d = lge_pkg::ST_ADV_WR;
				end
			end
			lge_pkg::ST_ADV_WR: begin
				mem_we = 1'b1;
				if (c_q == ncl_q) begin
					state_d = lge_pkg::ST_DONE;
				end else begin
					// The right neighbor of the last column is the saved old column zero.
					mem_raddr = ((c_q + CAW'(1)) == ncl_q) ? '0 : c_q + CAW'(2);
					state_d   = lge_pkg::ST_ADV_RD2;
				end
			end
			lge_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = lge_pkg::ST_IDLE;
				end
			end
			default: state_d = lge_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lge_pkg::ST_CLEAR;
			c_q         <= '0;
			r_q         <= '0;
			clr_reply_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				lge_pkg::ST_IDLE: begin
					if (accept) begin
						c_q         <= '0;
						clr_reply_q <= 1'b1;
					end
				end
				lge_pkg::ST_CLEAR: c_q <= c_q + CAW'(1);
				lge_pkg::ST_ADV_RD2: r_q <= '0;
				lge_pkg::ST_ADV_CELL: r_q <= r_q + RAW'(1);
				lge_pkg::ST_ADV_WR: begin
					if (c_q != ncl_q) begin
						c_q <= c_q + CAW'(1);
					end
				end
				default: ;
			endcase
			if ((state_q == lge_pkg::ST_DONE) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Grid memory: one column word per entry, registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= grid_mem[mem_raddr];
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			lge_pkg::ST_IDLE: begin
				if (accept) begin
					action_q     <= cmd.action;
					col_addr_q   <= CAW'(cmd.column_index);
					row_q        <= RAW'(cmd.row_index);
					oor_q        <= cmd_oor;
					ncl_q        <= CAW'(cols_last);
					nrl_q        <= RAW'(rows_last);
					res_value_q  <= 1'b0;
					res_status_q <= 1'b0;
				end
			end
			lge_pkg::ST_CELL: begin
				res_status_q <= oor_q;
				if (oor_q) begin
					res_value_q <= 1'b0;
				end else if (action_q == lge_pkg::ACT_TOGGLE) begin
					res_value_q <= ~cell_bit;
				end else begin
					res_value_q <= cell_bit;
				end
			end
			lge_pkg::ST_ADV_RD0: left_q <= rd_q;
			lge_pkg::ST_ADV_RD1: begin
				center_q <= rd_q;
				first_q  <= rd_q;
			end
			lge_pkg::ST_ADV_RD2: begin
				right_q <= (c_q == ncl_q) ? first_q : rd_q;
				// Rows outside the used size keep their old values.
				new_q   <= center_q;
			end
			lge_pkg::ST_ADV_CELL: new_q[r_q] <= alive_next;
			lge_pkg::ST_ADV_WR: begin
				left_q   <= center_q;
				center_q <= right_q;
			end
			lge_pkg::ST_DONE: begin
				if (out_free) begin
					res_q.cell_value <= res_value_q;
					res_q.status     <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`LGE_ASSERT_NEXT(a_busy_after_accept, accept, state_q != lge_pkg::ST_IDLE, "idle after accept")
	`LGE_ASSERT_SAME(a_row_in_range, state_q == lge_pkg::ST_ADV_CELL, r_q <= nrl_q, "row past used size")
	`LGE_ASSERT_SAME(a_col_in_range, state_q == lge_pkg::ST_ADV_WR, c_q <= ncl_q, "column past used size")

endmodule
